// ===== hdl/point_perspective_projector_assert.svh =====
// Assertion macros used by the checker file of the projector.
`ifndef POINT_PERSPECTIVE_PROJECTOR_ASSERT_SVH
`define POINT_PERSPECTIVE_PROJECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ppp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

    localparam int OUT_W     = 24;
    localparam int COEF_W    = 16;
    localparam int FIELD_W   = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int EDGE_W    = FIELD_W + 1;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    // Mode bits of the command
    localparam int CMD_UNBOUNDED_BIT = 0;
    localparam int CMD_FLAT_BIT      = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COL_ACROSS   = 3'd0,
        REG_COL_DOWN     = 3'd1,
        REG_COL_DEPTH    = 3'd2,
        REG_DEPTH_PLANES = 3'd3,
        REG_SCALE_CENTRE = 3'd4,
        REG_CLIP_WINDOW  = 3'd5,
        REG_CAMERA       = 3'd6
    } ppp_reg_t;

    // Per-item data that rides alongside the divider
    typedef struct packed {
        logic              drop;
        logic              fault;
        logic              unbounded;
        logic              neg_a;
        logic              neg_d;
        logic [OUT_W-1:0]  depth;
    } ppp_side_t;

endpackage

`default_nettype wire

// ===== hdl/point_perspective_projector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Projects one world point per cycle through a three-column camera matrix
// onto a clipped pixel window. Throughput is one point per clock while no
// finished result waits under out_stall. Each point passes the front stages
// and then the pipelined divider that retires one quotient bit per stage. The
// whole pipeline holds while a finished result waits under out_stall, and
// in_stall is raised only then. Configuration is taken at once by cfg_write
// and must only change while no point is in flight.
module point_perspective_projector
    import ppp_pkg::*;
#(
    parameter int COORD_WIDTH    = 18,
    parameter int COEF_FRAC_BITS = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic [FIELD_W-1:0]            spread,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_W-1:0]       across,
    output logic signed [OUT_W-1:0]       down,
    output logic signed [OUT_W-1:0]       depth,
    output logic                          on_screen,
    output logic                          divide_fault
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = COEF_FRAC_BITS;
    localparam int PW  = CW + COEF_W;
    localparam int TW  = ((PW > FIELD_W + F) ? PW : FIELD_W + F) + 2;
    localparam int DW  = TW;
    localparam int NW  = TW + FIELD_W;
    localparam int PLW = ((32 + F > TW) ? 32 + F : TW) + 1;
    localparam int EW  = NW + 2;
    localparam int SW  = $bits(ppp_side_t);

    // Configuration registers
    logic [CFG_W-1:0] cam_col_reg [0:2];
    logic [CFG_W-1:0] depth_planes_reg;
    logic [CFG_W-1:0] scale_centre_reg;
    logic [CFG_W-1:0] clip_window_reg;
    logic             camera_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_col_reg[0]   <= '0;
            cam_col_reg[1]   <= '0;
            cam_col_reg[2]   <= '0;
            depth_planes_reg <= '0;
            scale_centre_reg <= '0;
            clip_window_reg  <= '0;
            camera_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (ppp_reg_t'(cfg_index))
                REG_COL_ACROSS:   cam_col_reg[0]   <= cfg_data;
                REG_COL_DOWN:     cam_col_reg[1]   <= cfg_data;
                REG_COL_DEPTH:    cam_col_reg[2]   <= cfg_data;
                REG_DEPTH_PLANES: depth_planes_reg <= cfg_data;
                REG_SCALE_CENTRE: scale_centre_reg <= cfg_data;
                REG_CLIP_WINDOW:  clip_window_reg  <= cfg_data;
                REG_CAMERA:       camera_reg       <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Global advance: hold everything while the output waits
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage 1: coefficient products
    logic signed [CW-1:0] pt [0:2];
    logic signed [PW-1:0] prod_next [0:2][0:2];
    logic signed [PW-1:0] prod_reg  [0:2][0:2];
    logic                 v1_reg;
    logic [1:0]           cmd1_reg;
    logic [FIELD_W-1:0]   spread1_reg;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[c][k] = pt[k] * $signed(cam_col_reg[c][COEF_W*k +: COEF_W]);
            end
        end
    end

    // Stage 2: column sums with translation
    logic signed [TW-1:0] term_next [0:2];
    logic signed [TW-1:0] term_reg  [0:2];
    logic [TW-1:0]        tr_ext    [0:2];
    logic                 v2_reg;
    logic [1:0]           cmd2_reg;
    logic [FIELD_W-1:0]   spread2_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            tr_ext[c]    = {{(TW-COEF_W){cam_col_reg[c][CFG_W-1]}},
                            cam_col_reg[c][CFG_W-1 -: COEF_W]} << F;
            term_next[c] = prod_reg[c][0] + prod_reg[c][1] + prod_reg[c][2]
                         + $signed(tr_ext[c]);
        end
    end

    // Stage 3: magnitudes, divisor, plane test and depth output
    logic                 flat;
    logic                 unb;
    logic signed [TW-1:0] va;
    logic signed [TW-1:0] vd;
    logic signed [TW-1:0] vz;
    logic [TW-1:0]        mag_a_next;
    logic [TW-1:0]        mag_d_next;
    logic [DW-1:0]        den_next;
    logic                 den_zero;
    logic                 den_neg;
    logic [PLW-1:0]       near_ext;
    logic [PLW-1:0]       far_ext;
    logic [PLW-1:0]       vz_ext;
    logic                 plane_fail;
    logic signed [TW-1:0] vz_trunc;
    logic [OUT_W-1:0]     depth_sat;
    ppp_side_t            side3_next;
    logic [TW-1:0]        mag_a_reg;
    logic [TW-1:0]        mag_d_reg;
    logic [DW-1:0]        den3_reg;
    ppp_side_t            side3_reg;
    logic                 v3_reg;

    assign flat = cmd2_reg[CMD_FLAT_BIT];
    assign unb  = cmd2_reg[CMD_UNBOUNDED_BIT];
    assign va   = term_reg[0];
    assign vd   = term_reg[1];
    assign vz   = term_reg[2];

    always_comb
    begin
        mag_a_next = va[TW-1] ? TW'(-va) : TW'(va);
        mag_d_next = vd[TW-1] ? TW'(-vd) : TW'(vd);
        if (flat)
        begin
            den_next = DW'(spread2_reg) << F;
            den_zero = (spread2_reg == '0);
            den_neg  = 1'b0;
        end
        else
        begin
            den_next = vz[TW-1] ? DW'(-vz) : DW'(vz);
            den_zero = (vz == '0);
            den_neg  = vz[TW-1];
        end

        near_ext   = {{(PLW-32){depth_planes_reg[31]}}, depth_planes_reg[31:0]} << F;
        far_ext    = {{(PLW-32){depth_planes_reg[63]}}, depth_planes_reg[63:32]} << F;
        vz_ext     = {{(PLW-TW){vz[TW-1]}}, vz};
        plane_fail = ($signed(near_ext) > $signed(vz_ext))
                  || ($signed(vz_ext) > $signed(far_ext));

        // Truncate toward zero
        if (vz[TW-1])
        begin
            vz_trunc = (vz + $signed(TW'((1 << F) - 1))) >>> F;
        end
        else
        begin
            vz_trunc = vz >>> F;
        end
        if (vz_trunc > $signed(TW'(OUT_MAX)))
        begin
            depth_sat = OUT_W'(OUT_MAX);
        end
        else if (vz_trunc < $signed(TW'(OUT_MIN)))
        begin
            depth_sat = OUT_W'(OUT_MIN);
        end
        else
        begin
            depth_sat = vz_trunc[OUT_W-1:0];
        end

        side3_next.drop      = !camera_reg || den_zero || (!unb && plane_fail);
        side3_next.fault     = camera_reg && den_zero;
        side3_next.unbounded = unb;
        side3_next.neg_a     = va[TW-1] ^ den_neg;
        side3_next.neg_d     = vd[TW-1] ^ den_neg;
        side3_next.depth     = depth_sat;
    end

    // Stage 4: scale the numerators
    logic [NW-1:0] num_a_reg;
    logic [NW-1:0] num_d_reg;
    logic [DW-1:0] den4_reg;
    ppp_side_t     side4_reg;
    logic          v4_reg;

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= prod_next;
            cmd1_reg    <= cmd;
            spread1_reg <= spread;
            term_reg    <= term_next;
            cmd2_reg    <= cmd1_reg;
            spread2_reg <= spread1_reg;
            mag_a_reg   <= mag_a_next;
            mag_d_reg   <= mag_d_next;
            den3_reg    <= den_next;
            side3_reg   <= side3_next;
            num_a_reg   <= NW'(mag_a_reg) * NW'(scale_centre_reg[15:0]);
            num_d_reg   <= NW'(mag_d_reg) * NW'(scale_centre_reg[31:16]);
            den4_reg    <= den3_reg;
            side4_reg   <= side3_reg;
        end
    end

    // Division pipeline
    logic          vq_valid;
    logic [NW-1:0] quo_a;
    logic [NW-1:0] quo_d;
    logic          rem_a_nz;
    logic          rem_d_nz;
    logic [SW-1:0] side_q;

    ppp_divider #(
        .NW (NW),
        .DW (DW),
        .SW (SW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v4_reg),
        .num_a     (num_a_reg),
        .num_d     (num_d_reg),
        .den       (den4_reg),
        .side_in   (side4_reg),
        .out_valid (vq_valid),
        .quo_a     (quo_a),
        .quo_d     (quo_d),
        .rem_a_nz  (rem_a_nz),
        .rem_d_nz  (rem_d_nz),
        .side_out  (side_q)
    );

    // Stage 5: signed floor quotients
    ppp_side_t            side_div;
    logic signed [NW:0]   qa_next;
    logic signed [NW:0]   qd_next;
    logic signed [NW:0]   qa_reg;
    logic signed [NW:0]   qd_reg;
    logic                 ra_nz_reg;
    logic                 rd_nz_reg;
    ppp_side_t            side5_reg;
    logic                 v5_reg;

    assign side_div = ppp_side_t'(side_q);

    always_comb
    begin
        if (side_div.neg_a)
        begin
            qa_next = -$signed({1'b0, quo_a}) - $signed({{NW{1'b0}}, rem_a_nz});
        end
        else
        begin
            qa_next = $signed({1'b0, quo_a});
        end
        if (side_div.neg_d)
        begin
            qd_next = -$signed({1'b0, quo_d}) - $signed({{NW{1'b0}}, rem_d_nz});
        end
        else
        begin
            qd_next = $signed({1'b0, quo_d});
        end
    end

    // Stage 6: window test, offsets and saturation
    logic signed [EW-1:0] qa_x;
    logic signed [EW-1:0] qd_x;
    logic signed [EW-1:0] fl_x;
    logic signed [EW-1:0] fr_x;
    logic signed [EW-1:0] ft_x;
    logic signed [EW-1:0] fb_x;
    logic signed [EW-1:0] ta;
    logic signed [EW-1:0] td;
    logic                 fail_a;
    logic                 fail_d;
    logic                 drop_all;
    logic [OUT_W-1:0]     across_sat;
    logic [OUT_W-1:0]     down_sat;
    logic [OUT_W-1:0]     across_reg;
    logic [OUT_W-1:0]     down_reg;
    logic [OUT_W-1:0]     depth_reg;
    logic                 on_screen_reg;
    logic                 fault_reg;

    always_comb
    begin
        qa_x = EW'(qa_reg);
        qd_x = EW'(qd_reg);
        fl_x = EW'($signed({1'b0, clip_window_reg[15:0]}))
             - EW'($signed({1'b0, scale_centre_reg[47:32]}));
        fr_x = EW'($signed({1'b0, clip_window_reg[47:32]}))
             - EW'($signed({1'b0, scale_centre_reg[47:32]}));
        ft_x = EW'($signed({1'b0, clip_window_reg[31:16]}))
             - EW'($signed({1'b0, scale_centre_reg[63:48]}));
        fb_x = EW'($signed({1'b0, clip_window_reg[63:48]}))
             - EW'($signed({1'b0, scale_centre_reg[63:48]}));

        fail_a = (qa_x < fl_x) || (qa_x > fr_x) || ((qa_x == fr_x) && ra_nz_reg);
        fail_d = (qd_x < ft_x) || (qd_x > fb_x) || ((qd_x == fb_x) && rd_nz_reg);
        drop_all = side5_reg.drop || (!side5_reg.unbounded && (fail_a || fail_d));

        // Truncate the fractional landing toward zero
        ta = qa_x - fl_x;
        if (ta < 0 && ra_nz_reg)
        begin
            ta = ta + EW'(1);
        end
        td = qd_x - ft_x;
        if (td < 0 && rd_nz_reg)
        begin
            td = td + EW'(1);
        end

        if (ta > $signed(EW'(OUT_MAX)))
        begin
            across_sat = OUT_W'(OUT_MAX);
        end
        else if (ta < $signed(EW'(OUT_MIN)))
        begin
            across_sat = OUT_W'(OUT_MIN);
        end
        else
        begin
            across_sat = ta[OUT_W-1:0];
        end
        if (td > $signed(EW'(OUT_MAX)))
        begin
            down_sat = OUT_W'(OUT_MAX);
        end
        else if (td < $signed(EW'(OUT_MIN)))
        begin
            down_sat = OUT_W'(OUT_MIN);
        end
        else
        begin
            down_sat = td[OUT_W-1:0];
        end
    end

    // Valid bits of the back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg        <= vq_valid;
            out_valid_reg <= v5_reg;
        end
    end

    // Payload of the back stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qa_reg        <= qa_next;
            qd_reg        <= qd_next;
            ra_nz_reg     <= rem_a_nz;
            rd_nz_reg     <= rem_d_nz;
            side5_reg     <= side_div;
            across_reg    <= drop_all ? {OUT_W{1'b1}} : across_sat;
            down_reg      <= drop_all ? {OUT_W{1'b1}} : down_sat;
            depth_reg     <= drop_all ? {OUT_W{1'b1}} : side5_reg.depth;
            on_screen_reg <= !drop_all;
            fault_reg     <= side5_reg.fault;
        end
    end

    assign out_valid    = out_valid_reg;
    assign across       = across_reg;
    assign down         = down_reg;
    assign depth        = depth_reg;
    assign on_screen    = on_screen_reg;
    assign divide_fault = fault_reg;

endmodule

`default_nettype wire

// ===== hdl/ppp_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: two numerators over one divisor, one quotient
// bit per stage. The numerator register shifts out its top bit and takes the
// quotient bit in at the bottom, so it holds the quotient after NW stages.
module ppp_divider
    import ppp_pkg::*;
#(
    parameter int NW = 52,
    parameter int DW = 36,
    parameter int SW = 29
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] num_a,
    input  logic [NW-1:0] num_d,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo_a,
    output logic [NW-1:0] quo_d,
    output logic          rem_a_nz,
    output logic          rem_d_nz,
    output logic [SW-1:0] side_out
);

    logic          vld_reg  [1:NW];
    logic [NW-1:0] na_reg   [1:NW];
    logic [NW-1:0] nd_reg   [1:NW];
    logic [DW-1:0] ra_reg   [1:NW];
    logic [DW-1:0] rd_reg   [1:NW];
    logic [DW-1:0] dv_reg   [1:NW];
    logic [SW-1:0] side_reg [1:NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] a_in;
        logic [NW-1:0] d_in;
        logic [DW-1:0] ra_in;
        logic [DW-1:0] rd_in;
        logic [DW-1:0] dv_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   ta;
        logic [DW:0]   td;
        logic [DW:0]   da;
        logic [DW:0]   dd;
        logic          ga;
        logic          gd;

        // Select the stage input
        if (i == 0) begin : g_first
            assign v_in  = in_valid;
            assign a_in  = num_a;
            assign d_in  = num_d;
            assign ra_in = '0;
            assign rd_in = '0;
            assign dv_in = den;
            assign s_in  = side_in;
        end
        else begin : g_next
            assign v_in  = vld_reg[i];
            assign a_in  = na_reg[i];
            assign d_in  = nd_reg[i];
            assign ra_in = ra_reg[i];
            assign rd_in = rd_reg[i];
            assign dv_in = dv_reg[i];
            assign s_in  = side_reg[i];
        end

        // Shift in the next numerator bit and trial-subtract the divisor
        assign ta = {ra_in, a_in[NW-1]};
        assign td = {rd_in, d_in[NW-1]};
        assign da = ta - {1'b0, dv_in};
        assign dd = td - {1'b0, dv_in};
        assign ga = (ta >= {1'b0, dv_in});
        assign gd = (td >= {1'b0, dv_in});

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= v_in;
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                na_reg[i+1]   <= {a_in[NW-2:0], ga};
                nd_reg[i+1]   <= {d_in[NW-2:0], gd};
                ra_reg[i+1]   <= ga ? da[DW-1:0] : ta[DW-1:0];
                rd_reg[i+1]   <= gd ? dd[DW-1:0] : td[DW-1:0];
                dv_reg[i+1]   <= dv_in;
                side_reg[i+1] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[NW];
    assign quo_a     = na_reg[NW];
    assign quo_d     = nd_reg[NW];
    assign rem_a_nz  = (ra_reg[NW] != '0);
    assign rem_d_nz  = (rd_reg[NW] != '0);
    assign side_out  = side_reg[NW];

endmodule

`default_nettype wire

// ===== hdl/ppp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "point_perspective_projector_assert.svh"

module ppp_checker
    import ppp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_stall,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [OUT_W-1:0] across,
    input  logic signed [OUT_W-1:0] down,
    input  logic signed [OUT_W-1:0] depth,
    input  logic                    on_screen,
    input  logic                    divide_fault
);

    // A waiting result keeps its payload
    `PPP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(across) && $stable(down) && $stable(depth) && $stable(on_screen), "stalled result changed")

    // The input side is held back only by a waiting result
    `PPP_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a waiting result")

    // A zero divisor never lands
    `PPP_ASSERT_IMP(a_fault, clk, rst_n, out_valid && divide_fault, !on_screen, "fault with a landing")

    // The off-screen answer is all ones
    `PPP_ASSERT_IMP(a_nowhere, clk, rst_n, out_valid && !on_screen, (across == -1) && (down == -1) && (depth == -1), "off-screen answer not all ones")

endmodule

bind point_perspective_projector ppp_checker u_checker (.*);

`default_nettype wire
